[sv/wsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared constants, types and tables of the waypoint steering controller.
// ----------------------------------------------------------------------------
package wsc_pkg;

   localparam int WP_DEPTH     = 64;
   localparam int WP_AW        = $clog2(WP_DEPTH);
   localparam int CORDIC_ITER  = 14;
   localparam int ATAN_ENTRIES = 20;
   localparam int CORDIC_STEPS = (CORDIC_ITER < ATAN_ENTRIES) ? CORDIC_ITER : ATAN_ENTRIES;

   localparam int CW = 28;   // CORDIC x/y width
   localparam int ZW = 20;   // angle width, 2^-16 rad units
   localparam int RW = 22;   // angle difference and speed arithmetic width

   localparam int ANG_PI        = 205887;
   localparam int ANG_TWO_PI    = 411775;
   localparam int ANG_HPI_P1    = 102944;
   localparam int PROP_ROUND    = 102943;

   // turn rate: quotient by pi as a multiply by 2^48/pi, then one fix-up
   localparam int          RCP_SHIFT = 48;
   localparam logic [30:0] RCP_PI    = 31'((64'd1 << RCP_SHIFT) / 64'(ANG_PI));

   localparam int DIV_W      = 34;
   localparam int DIV_QW     = 16;
   localparam int MOD_STEPS  = WP_AW + 1;

   localparam int Q_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_MAX_SPEED = 2'd0,
      CSR_DIST_TOL  = 2'd1,
      CSR_ANG_TOL   = 2'd2,
      CSR_WP_COUNT  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [5:0]         slot;
      logic signed [15:0] wx;
      logic signed [15:0] wy;
      logic signed [15:0] px;
      logic signed [15:0] pz;
      logic signed [16:0] fx;
      logic signed [15:0] fz;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor_sh;
      logic [4:0]       steps;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_QW-1:0] quot;
      logic [DIV_W-1:0]  rem;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_DIFF, ST_SQX, ST_SQZ, ST_SQT, ST_CMP, ST_MOD,
      ST_CINIT, ST_CITER, ST_NORM, ST_DECIDE, ST_PROD, ST_DIV, ST_FIX, ST_OUT
   } back_state_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:  v = ZW'(51472);
         5'd1:  v = ZW'(30386);
         5'd2:  v = ZW'(16055);
         5'd3:  v = ZW'(8150);
         5'd4:  v = ZW'(4091);
         5'd5:  v = ZW'(2047);
         5'd6:  v = ZW'(1024);
         5'd7:  v = ZW'(512);
         5'd8:  v = ZW'(256);
         5'd9:  v = ZW'(128);
         5'd10: v = ZW'(64);
         5'd11: v = ZW'(32);
         5'd12: v = ZW'(16);
         5'd13: v = ZW'(8);
         5'd14: v = ZW'(4);
         5'd15: v = ZW'(2);
         5'd16: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
      logic signed [15:0] r;
      if (v > $signed(RW'(32767))) begin
         r = 16'sh7fff;
      end else if (v < -$signed(RW'(32768))) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

[sv/wsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_front
// Accepts items, classifies them and forms the front vector for the queue.
// ----------------------------------------------------------------------------
module wsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [5:0]           req_waypoint_slot,
   input  logic signed [15:0]   req_waypoint_x,
   input  logic signed [15:0]   req_waypoint_y,
   input  logic signed [15:0]   req_pos_x,
   input  logic signed [15:0]   req_pos_z,
   input  logic signed [15:0]   req_north_x,
   input  logic signed [15:0]   req_north_z,
   output logic                 push_valid,
   input  logic                 push_ready,
   output wsc_pkg::item_type    push_item
);
   import wsc_pkg::*;

   item_type hold_ff, hold_in;
   logic     hold_v_ff, hold_v_in;

   assign req_ready  = !hold_v_ff || push_ready;
   assign push_valid = hold_v_ff;
   assign push_item  = hold_ff;

   always_comb begin
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff && !push_ready;
      if (req_valid && req_ready) begin
         hold_v_in    = 1'b1;
         hold_in.op   = req_op ? OP_SAMPLE : OP_LOAD;
         hold_in.slot = req_waypoint_slot;
         hold_in.wx   = req_waypoint_x;
         hold_in.wy   = req_waypoint_y;
         hold_in.px   = req_pos_x;
         hold_in.pz   = req_pos_z;
         // robot front is (-north_x, north_z)
         hold_in.fx   = -$signed({req_north_x[15], req_north_x});
         hold_in.fz   = req_north_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
      hold_ff <= hold_in;
   end

endmodule

[sv/wsc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module wsc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wsc_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wsc_pkg::item_type pop_item
);
   import wsc_pkg::*;

   localparam int QAW = $clog2(Q_DEPTH);
   localparam int QCW = $clog2(Q_DEPTH + 1);

   item_type          ent_ff [Q_DEPTH];
   logic [QAW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0]    cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = cnt_ff != QCW'(Q_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_item   = ent_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QAW'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QAW'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         ent_ff[wr_ff] <= push_item;
      end
   end

endmodule

[sv/wsc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_div
// Restoring divider, one quotient bit per cycle, for the waypoint index wrap.
// ----------------------------------------------------------------------------
module wsc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wsc_pkg::div_req_type div_req,
   output wsc_pkg::div_rsp_type div_rsp
);
   import wsc_pkg::*;

   logic [DIV_W-1:0]  rem_ff, rem_in, dsh_ff, dsh_in;
   logic [DIV_QW-1:0] q_ff, q_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;
   assign div_rsp.rem  = rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsh_in  = div_req.divisor_sh;
         q_in    = '0;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[DIV_QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[DIV_QW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

endmodule

[sv/wsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_back
// Waypoint table, distance test, shared CORDIC, heading error and wheel speeds.
// ----------------------------------------------------------------------------
module wsc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  wsc_pkg::item_type       q_item,
   input  logic                    csr_we,
   input  wsc_pkg::csr_idx_type    csr_index,
   input  logic [14:0]             csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_left_speed,
   output logic signed [15:0]      rsp_right_speed,
   output logic                    rsp_reached,
   output logic [5:0]              rsp_target_slot
);
   import wsc_pkg::*;

   logic [31:0] wp_mem [WP_DEPTH];
   logic [31:0] rd_ff;

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;

   logic signed [16:0]  dx_ff, dx_in, dz_ff, dz_in;
   logic [DIV_W-1:0]    p1_ff, p1_in, p2_ff, p2_in, prod_ff, prod_in;
   logic [23:0]         tol2_ff, tol2_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in, adir_ff, adir_in;
   logic [4:0]          it_ff, it_in;
   logic                sel_ff, sel_in;
   logic signed [RW-1:0] r_ff, r_in, beta_ff, beta_in;
   logic [WP_AW-1:0]    target_ff, target_in;
   logic [47:0]         pl_ff, pl_in, ph_ff, ph_in;
   logic [15:0]         qe_ff, qe_in;

   logic [14:0] max_ff, max_in;
   logic [11:0] dtol_ff, dtol_in;
   logic [13:0] atol_ff, atol_in;
   logic [6:0]  wcnt_ff, wcnt_in;

   logic signed [15:0] res_l_ff, res_l_in, res_r_ff, res_r_in;
   logic               res_reached_ff, res_reached_in;

   logic               out_v_ff, out_v_in, out_load;
   logic signed [15:0] out_l_ff, out_r_ff;
   logic               out_reached_ff;
   logic [5:0]         out_slot_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [WP_AW:0]       cnt_eff;
   logic                 mem_we;
   logic signed [16:0]   vx, vy;
   logic signed [CW-1:0] sx, sy, xs, ys;
   logic signed [ZW-1:0] zres;
   logic                 zfin;
   logic signed [RW-1:0] tol, base;
   logic [64:0]          pq;
   logic [DIV_W-1:0]     qpi, fix_rem;
   logic [15:0]          qfix;

   wsc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign q_ready = (state_ff == ST_IDLE);
   assign mem_we  = (state_ff == ST_IDLE) && q_valid && (q_item.op == OP_LOAD)
                    && (int'(q_item.slot) < WP_DEPTH);

   assign rsp_valid       = out_v_ff;
   assign rsp_left_speed  = out_l_ff;
   assign rsp_right_speed = out_r_ff;
   assign rsp_reached     = out_reached_ff;
   assign rsp_target_slot = out_slot_ff;

   // zero count acts as one, oversize count as the table depth
   always_comb begin
      if (wcnt_ff == '0) begin
         cnt_eff = (WP_AW+1)'(1);
      end else if (int'(wcnt_ff) > WP_DEPTH) begin
         cnt_eff = (WP_AW+1)'(WP_DEPTH);
      end else begin
         cnt_eff = (WP_AW+1)'(wcnt_ff);
      end
   end

   always_comb begin
      max_in  = max_ff;
      dtol_in = dtol_ff;
      atol_in = atol_ff;
      wcnt_in = wcnt_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_SPEED: max_in  = csr_wdata;
            CSR_DIST_TOL:  dtol_in = csr_wdata[11:0];
            CSR_ANG_TOL:   atol_in = csr_wdata[13:0];
            CSR_WP_COUNT:  wcnt_in = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      dx_in          = dx_ff;
      dz_in          = dz_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      tol2_in        = tol2_ff;
      prod_in        = prod_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      it_in          = it_ff;
      sel_in         = sel_ff;
      adir_in        = adir_ff;
      r_in           = r_ff;
      beta_in        = beta_ff;
      target_in      = target_ff;
      pl_in          = pl_ff;
      ph_in          = ph_ff;
      qe_in          = qe_ff;
      res_l_in       = res_l_ff;
      res_r_in       = res_r_ff;
      res_reached_in = res_reached_ff;
      div_req        = '0;
      out_load       = 1'b0;
      out_v_in       = out_v_ff && !rsp_ready;
      vx             = sel_ff ? item_ff.fx : dx_ff;
      vy             = sel_ff ? 17'(item_ff.fz) : dz_ff;
      sx             = CW'(vx) <<< 8;
      sy             = CW'(vy) <<< 8;
      xs             = x_ff >>> it_ff;
      ys             = y_ff >>> it_ff;
      zres           = '0;
      zfin           = 1'b0;
      tol            = RW'({atol_ff, 4'b0000});
      base           = $signed(RW'({max_ff, 4'b0000})) - RW'(ANG_PI);
      pq             = {ph_ff, 17'b0} + 65'(pl_ff);
      qpi            = DIV_W'(qe_ff * 18'(ANG_PI));
      fix_rem        = prod_ff - qpi;
      // the estimate is low by at most one
      qfix           = (fix_rem >= DIV_W'(ANG_PI)) ? qe_ff + 16'd1 : qe_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.op == OP_SAMPLE)) begin
               item_in  = q_item;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: begin
            dx_in    = $signed({rd_ff[31], rd_ff[31:16]}) - 17'(item_ff.px);
            dz_in    = $signed({rd_ff[15], rd_ff[15:0]}) - 17'(item_ff.pz);
            state_in = ST_SQX;
         end
         ST_SQX: begin
            p1_in    = DIV_W'(dx_ff * dx_ff);
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            p2_in    = DIV_W'(dz_ff * dz_ff);
            state_in = ST_SQT;
         end
         ST_SQT: begin
            tol2_in  = 24'(dtol_ff * dtol_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((35'(p1_ff) + 35'(p2_ff)) < 35'(tol2_ff)) begin
               div_req.start      = 1'b1;
               div_req.dividend   = DIV_W'(target_ff) + DIV_W'(1);
               div_req.divisor_sh = DIV_W'(cnt_eff) << WP_AW;
               div_req.steps      = 5'(MOD_STEPS);
               state_in           = ST_MOD;
            end else begin
               sel_in   = 1'b0;
               state_in = ST_CINIT;
            end
         end
         ST_MOD: begin
            if (div_rsp.done) begin
               target_in      = WP_AW'(div_rsp.rem);
               res_l_in       = '0;
               res_r_in       = '0;
               res_reached_in = 1'b1;
               state_in       = ST_OUT;
            end
         end
         ST_CINIT: begin
            it_in = '0;
            if (vx == '0 && vy == '0) begin
               zfin = 1'b1;
            end else begin
               state_in = ST_CITER;
               if (vx < 0) begin
                  if (vy >= 0) begin
                     x_in = sy;
                     y_in = -sx;
                     z_in = ZW'(ANG_HPI_P1);
                  end else begin
                     x_in = -sy;
                     y_in = sx;
                     z_in = -ZW'(ANG_HPI_P1);
                  end
               end else begin
                  x_in = sx;
                  y_in = sy;
                  z_in = '0;
               end
            end
         end
         ST_CITER: begin
            if (y_ff >= 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_entry(it_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_entry(it_ff);
            end
            it_in = it_ff + 1'b1;
            if (it_ff == 5'(CORDIC_STEPS - 1)) begin
               zres = z_in;
               zfin = 1'b1;
            end
         end
         ST_NORM: begin
            // fold into [0, 2pi), one correction a cycle
            if (r_ff < 0) begin
               r_in = r_ff + RW'(ANG_TWO_PI);
            end else if (r_ff >= RW'(ANG_TWO_PI)) begin
               r_in = r_ff - RW'(ANG_TWO_PI);
            end else begin
               beta_in  = r_ff - RW'(ANG_PI);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_reached_in = 1'b0;
            if (beta_ff > tol) begin
               prod_in  = DIV_W'(max_ff * beta_ff[17:0]) + DIV_W'(PROP_ROUND);
               state_in = ST_PROD;
            end else if (beta_ff < -tol) begin
               res_l_in = -$signed({1'b0, max_ff});
               res_r_in = $signed({1'b0, max_ff});
               state_in = ST_OUT;
            end else begin
               res_l_in = sat16((base + beta_ff + RW'(8)) >>> 4);
               res_r_in = sat16((base - beta_ff + RW'(8)) >>> 4);
               state_in = ST_OUT;
            end
         end
         ST_PROD: begin
            // split the numerator so each product stays narrow
            pl_in    = 48'(prod_ff[16:0] * RCP_PI);
            ph_in    = 48'(prod_ff[33:17] * RCP_PI);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            qe_in    = pq[RCP_SHIFT+15:RCP_SHIFT];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            res_l_in = $signed(qfix);
            res_r_in = -$signed(qfix);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!out_v_ff || rsp_ready) begin
               out_load = 1'b1;
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (zfin) begin
         if (!sel_ff) begin
            adir_in  = zres;
            sel_in   = 1'b1;
            state_in = ST_CINIT;
         end else begin
            r_in     = RW'(adir_ff) - RW'(zres);
            state_in = ST_NORM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         target_ff <= '0;
         out_v_ff  <= 1'b0;
         max_ff    <= 15'd20480;
         dtol_ff   <= 12'd41;
         atol_ff   <= 14'd205;
         wcnt_ff   <= 7'd1;
      end else begin
         state_ff  <= state_in;
         target_ff <= target_in;
         out_v_ff  <= out_v_in;
         max_ff    <= max_in;
         dtol_ff   <= dtol_in;
         atol_ff   <= atol_in;
         wcnt_ff   <= wcnt_in;
      end
      item_ff        <= item_in;
      dx_ff          <= dx_in;
      dz_ff          <= dz_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      tol2_ff        <= tol2_in;
      prod_ff        <= prod_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      it_ff          <= it_in;
      sel_ff         <= sel_in;
      adir_ff        <= adir_in;
      r_ff           <= r_in;
      beta_ff        <= beta_in;
      pl_ff          <= pl_in;
      ph_ff          <= ph_in;
      qe_ff          <= qe_in;
      res_l_ff       <= res_l_in;
      res_r_ff       <= res_r_in;
      res_reached_ff <= res_reached_in;
      if (out_load) begin
         out_l_ff       <= res_l_ff;
         out_r_ff       <= res_r_ff;
         out_reached_ff <= res_reached_ff;
         out_slot_ff    <= 6'(target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wp_mem[WP_AW'(q_item.slot)] <= {q_item.wx, q_item.wy};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= wp_mem[target_ff];
      end
   end

   a_reach_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_reached_ff |-> out_l_ff == 16'sd0 && out_r_ff == 16'sd0)
      else $error("reached item carries nonzero speed");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_MOD)
      else $error("divider result with no waiting step");

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CITER |-> it_ff < 5'(CORDIC_STEPS))
      else $error("CORDIC iteration count overrun");

endmodule

[sv/waypoint_steering_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_steering_controller_unit
// Steers a two-wheeled robot through a table of stored waypoints.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input items, valid/ready. op 0 loads a waypoint slot and gives no
//            result; op 1 is a position and compass sample and gives one
//            result item on rsp_*.
//   rsp_*  : wheel speeds, reached flag and the slot pursued after the step,
//            valid/ready from an output register.
//   csr_*  : register writes (max speed, distance and angle tolerance, waypoint
//            count); the user writes only while idle, unenforced by the block.
// Flow:
//   An item passes the front register and then the queue. A load item is
//   written into the waypoint table by the idle back end. A sample reads its
//   waypoint and tests the distance; when the waypoint is reached, the target
//   index wraps in the divider (seven-step index wrap), else the sample takes
//   two passes of the shared CORDIC unit (a zero vector skips the iterations),
//   angle folding, and for a proportional turn the reciprocal multiply and fix-up.
//   The back end works on one sample at a time; a two-entry queue and the
//   front register keep accepting items while it is busy, until they fill.
// Reset clears the target index to slot 0 and loads the register defaults;
// the waypoint table is undefined until written. When the receiver stalls,
// the result waits in the output register, and the next one waits in ST_OUT.
module waypoint_steering_controller_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [5:0]           req_waypoint_slot,
   input  logic signed [15:0]   req_waypoint_x,
   input  logic signed [15:0]   req_waypoint_y,
   input  logic signed [15:0]   req_pos_x,
   input  logic signed [15:0]   req_pos_z,
   input  logic signed [15:0]   req_north_x,
   input  logic signed [15:0]   req_north_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_left_speed,
   output logic signed [15:0]   rsp_right_speed,
   output logic                 rsp_reached,
   output logic [5:0]           rsp_target_slot,
   input  logic                 csr_we,
   input  wsc_pkg::csr_idx_type csr_index,
   input  logic [14:0]          csr_wdata
);
   import wsc_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   wsc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_waypoint_slot (req_waypoint_slot),
      .req_waypoint_x    (req_waypoint_x),
      .req_waypoint_y    (req_waypoint_y),
      .req_pos_x         (req_pos_x),
      .req_pos_z         (req_pos_z),
      .req_north_x       (req_north_x),
      .req_north_z       (req_north_z),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   wsc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   wsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (pop_valid),
      .q_ready         (pop_ready),
      .q_item          (pop_item),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_reached     (rsp_reached),
      .rsp_target_slot (rsp_target_slot)
   );

endmodule
